// File: hdl/ptlt_pkg.sv
package ptlt_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 32;
   localparam int KEY_W                 = 50;
   localparam int SLOT_W                = 5;
   localparam int INTERVAL_W            = 16;
   localparam int TIME_W                = 32;
   localparam int COUNT_W               = 32;

   localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RESET = 16'd1000;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] last_seen;
      logic [TIME_W-1:0] last_report;
      logic              reported_ever;
      logic              code_known;
      logic [15:0]       code;
      logic [7:0]        tag;
      logic [7:0]        signal;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: hdl/peer_table_lru_tracker_unit.sv
// Tracks recently heard advertisers in a table of TABLE_ENTRIES entries held in one
// synchronous RAM, with the valid bits in flip-flops. Each accepted event is looked up by
// its 50-bit key (address type and address); a miss takes the first free entry or, when
// the table is full, the entry with the oldest last-seen time, lowest index on ties. One
// transfer on the rsp_ channel follows every transfer on the req_ channel. The result comes
// from a sweep that reads one entry a cycle through the RAM's single read port, a step to
// take in the last entry read, then one read and one write-back of the chosen entry.
// A new event is taken in the cycle after the write-back, and it is taken even while the
// previous result still waits on rsp_stall; a result that is still waiting holds the
// next write-back. The report interval may be written only while the block is idle.
module peer_table_lru_tracker_unit #(
   parameter int TABLE_ENTRIES = ptlt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ptlt_pkg::INTERVAL_W-1:0]    csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [47:0]                        req_peer_address,
   input  logic [1:0]                         req_address_kind,
   input  logic signed [7:0]                  req_signal_dbm,
   input  logic [31:0]                        req_time_ms,
   input  logic                               req_code_present,
   input  logic [15:0]                        req_code_value,
   input  logic [7:0]                         req_tag_number,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ptlt_pkg::SLOT_W-1:0]        rsp_entry_slot,
   output logic                               rsp_entry_created,
   output logic                               rsp_report_due,
   output logic [15:0]                        rsp_stored_code,
   output logic [7:0]                         rsp_stored_tag,
   output logic signed [7:0]                  rsp_stored_signal,
   output logic [31:0]                        rsp_events_total,
   output logic [31:0]                        rsp_entries_created_total,
   output logic [31:0]                        rsp_coded_total
);

   import ptlt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_FETCH  = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [INTERVAL_W-1:0]    interval_ff;
   logic [TABLE_ENTRIES-1:0] entry_valid_ff;
   logic [COUNT_W-1:0]       events_ff, created_cnt_ff, coded_cnt_ff;

   logic [KEY_W-1:0]  key_ff;
   logic [7:0]        sig_ff;
   logic [TIME_W-1:0] now_ff;
   logic              has_code_ff;
   logic [15:0]       code_ff;
   logic [7:0]        tag_ff;

   logic [IDX_W-1:0]  scan_idx_ff;
   logic              chk_valid_ff;
   logic [IDX_W-1:0]  chk_idx_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [IDX_W-1:0]  victim_idx_ff;
   logic [TIME_W-1:0] victim_time_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic              created_ff;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_slot_ff;
   logic              rsp_created_ff;
   logic              rsp_due_ff;
   logic [15:0]       rsp_code_ff;
   logic [7:0]        rsp_tag_ff;
   logic [7:0]        rsp_signal_ff;

   logic              accept;
   logic              commit;
   logic              out_free;
   logic [IDX_W-1:0]  slot_sel;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type         rd_entry;
   entry_type         base_entry;
   entry_type         new_entry;
   logic              due;
   logic [TIME_W-1:0] elapsed;
   logic              chk_entry_valid;
   logic [SLOT_W+IDX_W-1:0] slot_wide;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_UPDATE) && out_free;
   assign req_stall = (state_ff != ST_IDLE);

   assign slot_sel = hit_ff ? hit_idx_ff : (free_found_ff ? free_idx_ff : victim_idx_ff);

   assign ram_rd_en   = (state_ff == ST_SCAN) || (state_ff == ST_FETCH);
   assign ram_rd_addr = (state_ff == ST_SCAN) ? scan_idx_ff : slot_sel;

   ptlt_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (slot_ff),
      .wr_data (new_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry        = entry_type'(ram_rd_data);
   assign chk_entry_valid = entry_valid_ff[chk_idx_ff];

   always_comb begin
      base_entry = rd_entry;
      if (created_ff) begin
         base_entry = '0;
         base_entry.key = key_ff;
      end
      new_entry           = base_entry;
      new_entry.signal    = sig_ff;
      new_entry.last_seen = now_ff;
      if (has_code_ff) begin
         new_entry.code_known = 1'b1;
         new_entry.code       = code_ff;
         new_entry.tag        = tag_ff;
      end
      elapsed = now_ff - base_entry.last_report;
      due = 1'b0;
      if (new_entry.code_known) begin
         if (!base_entry.reported_ever) begin
            due = 1'b1;
         end else if (now_ff >= base_entry.last_report &&
                      elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_ff}) begin
            due = 1'b1;
         end
      end
      if (due) begin
         new_entry.last_report   = now_ff;
         new_entry.reported_ever = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         interval_ff    <= REPORT_INTERVAL_RESET;
         entry_valid_ff <= '0;
         events_ff      <= '0;
         created_cnt_ff <= '0;
         coded_cnt_ff   <= '0;
         chk_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= (state_ff == ST_SCAN);
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         if (commit) begin
            entry_valid_ff[slot_ff] <= 1'b1;
            events_ff <= events_ff + COUNT_W'(1);
            if (created_ff) begin
               created_cnt_ff <= created_cnt_ff + COUNT_W'(1);
            end
            if (has_code_ff) begin
               coded_cnt_ff <= coded_cnt_ff + COUNT_W'(1);
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff        <= {req_address_kind, req_peer_address};
         sig_ff        <= $unsigned(req_signal_dbm);
         now_ff        <= req_time_ms;
         has_code_ff   <= req_code_present;
         code_ff       <= req_code_value;
         tag_ff        <= req_tag_number;
         scan_idx_ff   <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
      chk_idx_ff <= scan_idx_ff;
      if (chk_valid_ff) begin
         if (chk_entry_valid && rd_entry.key == key_ff && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= chk_idx_ff;
         end
         if (!chk_entry_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= chk_idx_ff;
         end
         if (chk_entry_valid &&
             (chk_idx_ff == '0 || rd_entry.last_seen < victim_time_ff)) begin
            victim_idx_ff  <= chk_idx_ff;
            victim_time_ff <= rd_entry.last_seen;
         end
      end
      if (state_ff == ST_FETCH) begin
         slot_ff    <= slot_sel;
         created_ff <= !hit_ff;
      end
      if (commit) begin
         rsp_slot_ff    <= slot_ff;
         rsp_created_ff <= created_ff;
         rsp_due_ff     <= due;
         rsp_code_ff    <= new_entry.code;
         rsp_tag_ff     <= new_entry.tag;
         rsp_signal_ff  <= new_entry.signal;
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, rsp_slot_ff};

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_entry_slot            = slot_wide[SLOT_W-1:0];
   assign rsp_entry_created         = rsp_created_ff;
   assign rsp_report_due            = rsp_due_ff;
   assign rsp_stored_code           = rsp_code_ff;
   assign rsp_stored_tag            = rsp_tag_ff;
   assign rsp_stored_signal         = $signed(rsp_signal_ff);
   assign rsp_events_total          = events_ff;
   assign rsp_entries_created_total = created_cnt_ff;
   assign rsp_coded_total           = coded_cnt_ff;

   // The written entry must be marked valid as its result appears.
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid && entry_valid_ff[slot_ff]))
      else $error("written entry not valid after transfer");

   a_event_count: assert property (@(posedge clock) disable iff (reset)
      commit |=> (events_ff == $past(events_ff) + COUNT_W'(1)))
      else $error("event count did not advance by one");

   // A new entry in a table that is not full must land on a free entry.
   a_free_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && !hit_ff && free_found_ff) |=> !entry_valid_ff[slot_ff])
      else $error("allocation overwrote a valid entry while a free one existed");

endmodule

// File: hdl/ptlt_ram.sv
module ptlt_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
